// ===== rtl/assert_macros.svh =====
// assertion macros shared by the line stepper rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define BLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is asserted
`define BLS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is asserted
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bls_pkg.sv =====
// shared types for the line stepper: line case codes and back-end states
// no dependencies
package bls_pkg;

	// line orientation decided by the front end
	typedef enum logic [1:0] {
		CASE_IDLE   = 2'd0,
		CASE_XMAJOR = 2'd1,
		CASE_YMAJOR = 2'd2,
		CASE_DIAG   = 2'd3
	} line_case_t;

	// back-end stepper states
	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RUN  = 1'b1
	} bk_state_t;

endpackage

// ===== rtl/bls_front.sv =====
// front end: accepts line requests, works out deltas, directions and case
// depends on bls_pkg
module bls_front #(
	parameter int COORD_BITS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   start_x,
	input  logic [COORD_BITS-1:0]   start_y,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	output logic                    desc_valid,
	input  logic                    desc_ready,
	output logic [6*COORD_BITS+3:0] desc_data
);
	import bls_pkg::*;

	localparam int DESC_W = 6 * COORD_BITS + 4;

	logic                  x_neg, y_neg;
	logic [COORD_BITS-1:0] abs_dx, abs_dy, major_d, minor_d;
	line_case_t            lcase;
	logic                  vld_s1;
	logic [DESC_W-1:0]     desc_s1;

	// direction flags and absolute deltas
	always_comb begin
		x_neg  = end_x < start_x;
		y_neg  = end_y < start_y;
		abs_dx = x_neg ? (start_x - end_x) : (end_x - start_x);
		abs_dy = y_neg ? (start_y - end_y) : (end_y - start_y);
	end

	// classify and pick major and minor deltas
	always_comb begin
		if (abs_dx > abs_dy) begin
			lcase   = CASE_XMAJOR;
			major_d = abs_dx;
			minor_d = abs_dy;
		end else if (abs_dy > abs_dx) begin
			lcase   = CASE_YMAJOR;
			major_d = abs_dy;
			minor_d = abs_dx;
		end else begin
			lcase   = CASE_DIAG;
			major_d = abs_dx;
			minor_d = abs_dy;
		end
	end

	// stage register toward the queue
	assign in_ready   = !vld_s1 || desc_ready;
	assign desc_valid = vld_s1;
	assign desc_data  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			desc_s1 <= {start_x, start_y, end_x, end_y, major_d, minor_d,
				x_neg, y_neg, lcase};
		end
	end

endmodule

// ===== rtl/bls_fifo.sv =====
// short descriptor queue between front end and stepper
// depends on assert_macros.svh
module bls_fifo #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	`include "assert_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign wr_ready = cnt_q != FULL_CNT;
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// occupancy checks
	`BLS_ASSERT(a_cnt_bound, cnt_q <= FULL_CNT, "queue count above depth")
	`BLS_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count missed a push")
	`BLS_ASSERT_NEXT(a_cnt_dec, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "count missed a pop")

endmodule

// ===== rtl/bls_back.sv =====
// back end: steps one line descriptor into pixels, one beat per cycle while the receiver takes them
// depends on bls_pkg and assert_macros.svh
module bls_back #(
	parameter int COORD_BITS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    desc_valid,
	output logic                    desc_ready,
	input  logic [6*COORD_BITS+3:0] desc_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COORD_BITS-1:0]   point_x,
	output logic [COORD_BITS-1:0]   point_y,
	output logic                    last_point
);
	import bls_pkg::*;
	`include "assert_macros.svh"

	localparam int CB = COORD_BITS;
	localparam int AW = COORD_BITS + 2;

	// descriptor fields
	logic [CB-1:0] d_sx, d_sy, d_ex, d_ey, d_major, d_minor;
	logic          d_xneg, d_yneg;
	line_case_t    d_case;

	assign d_sx    = desc_data[6*CB+3 -: CB];
	assign d_sy    = desc_data[5*CB+3 -: CB];
	assign d_ex    = desc_data[4*CB+3 -: CB];
	assign d_ey    = desc_data[3*CB+3 -: CB];
	assign d_major = desc_data[2*CB+3 -: CB];
	assign d_minor = desc_data[CB+3 -: CB];
	assign d_xneg  = desc_data[3];
	assign d_yneg  = desc_data[2];
	assign d_case  = line_case_t'(desc_data[1:0]);

	bk_state_t     state_q, state_d;
	logic [CB-1:0] cur_x_q, cur_y_q, tx_q, ty_q, major_q, minor_q, n_q;
	logic          xneg_q, yneg_q;
	line_case_t    case_q;
	logic [AW-1:0] acc1_q, acc2_q, acc1_d, acc2_d;
	logic          out_valid_q, last_q;
	logic [CB-1:0] px_q, py_q;

	logic          slot_free, load, emit, done, minor_go, step_x, step_y;
	logic [CB-1:0] nx, ny;

	assign slot_free = !out_valid_q || out_ready;
	assign done      = n_q == major_q;
	assign minor_go  = acc1_q > acc2_q;

	// which axes move on this step
	always_comb begin
		unique case (case_q)
			CASE_XMAJOR: begin
				step_x = 1'b1;
				step_y = minor_go;
			end
			CASE_YMAJOR: begin
				step_x = minor_go;
				step_y = 1'b1;
			end
			CASE_DIAG: begin
				step_x = 1'b1;
				step_y = 1'b1;
			end
			default: begin
				step_x = 1'b0;
				step_y = 1'b0;
			end
		endcase
	end

	// next coordinates, wrapping at the coordinate width
	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		if (step_x) begin
			nx = xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (step_y) begin
			ny = yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	// error accumulator update
	always_comb begin
		if (minor_go) begin
			acc2_d = acc2_q + AW'(major_q) - acc1_q;
			acc1_d = AW'(minor_q);
		end else begin
			acc2_d = acc2_q;
			acc1_d = acc1_q + AW'(minor_q);
		end
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		emit       = 1'b0;
		desc_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				desc_ready = 1'b1;
				if (desc_valid) begin
					load    = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (done) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			case_q      <= CASE_IDLE;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				case_q <= d_case;
			end else if (emit && done) begin
				case_q <= CASE_IDLE;
			end
		end
	end

	// line registers and output beat
	always_ff @(posedge clk) begin
		if (load) begin
			cur_x_q <= d_sx;
			cur_y_q <= d_sy;
			tx_q    <= d_ex;
			ty_q    <= d_ey;
			major_q <= d_major;
			minor_q <= d_minor;
			xneg_q  <= d_xneg;
			yneg_q  <= d_yneg;
			acc1_q  <= '0;
			acc2_q  <= '0;
			n_q     <= '0;
		end else if (emit && !done) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			acc1_q  <= acc1_d;
			acc2_q  <= acc2_d;
			n_q     <= n_q + 1'b1;
		end
		if (emit) begin
			px_q   <= done ? tx_q : cur_x_q;
			py_q   <= done ? ty_q : cur_y_q;
			last_q <= done;
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = px_q;
	assign point_y    = py_q;
	assign last_point = last_q;

	// stepper checks
	`BLS_ASSERT_IMPL(a_cnt_le_major, state_q == BK_RUN, n_q <= major_q, "step count past major delta")
	`BLS_ASSERT_NEXT(a_last_beat, emit && done, out_valid && last_point, "end point beat missing")
	`BLS_ASSERT_NEXT(a_inner_beat, emit && !done, out_valid && !last_point, "inner point flagged last")

endmodule

// ===== rtl/bresenham_line_stepper_unit.sv =====
// bresenham line stepper: one line request in, every pixel of the line out
// Input channel in_valid/in_ready carries start_x, start_y, end_x, end_y.
// Output channel out_valid/out_ready carries point_x, point_y, last_point;
// the end point always comes last, with last_point set. A line whose start
// equals its end gives a single beat.
// A line of major delta D gives D+1 beats, one per cycle while the
// receiver takes them; the stepper then returns to idle to load the next
// descriptor, so it takes no new line before it is through with the last.
// The back end has a single stepper, so lines are stepped one at a time.
// A request passes the front stage register, the queue write, the stepper
// load and the output register before its first beat appears.
// The front end classifies requests; up to QUEUE_DEPTH of them wait in the
// queue, plus one in the front stage, while the stepper works.
// When the receiver stalls, the output beat holds and the stepper waits.
// Reset clears all handshake and control state; no item is in flight after.
// depends on bls_pkg, bls_front, bls_fifo, bls_back
module bresenham_line_stepper_unit #(
	parameter int COORD_BITS  = 6,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic                  last_point
);
	localparam int DESC_W = 6 * COORD_BITS + 4;

	logic              f_valid, f_ready, q_valid, q_ready;
	logic [DESC_W-1:0] f_data, q_data;

	// classify requests
	bls_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.desc_valid (f_valid),
		.desc_ready (f_ready),
		.desc_data  (f_data)
	);

	// descriptor queue
	bls_fifo #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	// pixel stepper
	bls_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc_ready (q_ready),
		.desc_data  (q_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

endmodule

// ===== bench/tb_bresenham_line_stepper_unit.sv =====
// testbench for bresenham_line_stepper_unit: queued line requests, a pixel
// predictor, and a beat-by-beat check of every emitted point
// depends on bls_pkg and the bresenham_line_stepper_unit rtl
module tb_bresenham_line_stepper_unit;
	import bls_pkg::*;

	localparam int COORD_BITS = 6;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS+1:0] acc_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} line_req_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		logic   last;
	} pixel_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;

	line_req_t pending_lines[$];
	pixel_t    expected_pixels[$];
	int        lines_taken = 0;
	int        failures = 0;
	logic      quiet;

	bresenham_line_stepper_unit #(.COORD_BITS(COORD_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point)
	);

	// no idling on either side for a stretch of lines in the middle of the run
	assign quiet = (lines_taken >= 70) && (lines_taken < 110);

	initial begin
		forever #4 clk = ~clk;
	end

	// expand one line into its pixels with the two-accumulator error rule
	function automatic void plot_line(input line_req_t req);
		coord_t     px, py, adx, ady;
		logic       x_back, y_back;
		acc_t       acc_one, acc_two;
		line_case_t orient;
		int         steps;
		int         n;
		px = req.sx;
		py = req.sy;
		x_back = req.ex < req.sx;
		y_back = req.ey < req.sy;
		adx = x_back ? req.sx - req.ex : req.ex - req.sx;
		ady = y_back ? req.sy - req.ey : req.ey - req.sy;
		acc_one = '0;
		acc_two = '0;
		if (adx > ady) orient = CASE_XMAJOR;
		else if (ady > adx) orient = CASE_YMAJOR;
		else orient = CASE_DIAG;
		steps = (orient == CASE_YMAJOR) ? int'(ady) : int'(adx);
		for (n = 0; n < steps; n++) begin
			expected_pixels.push_back('{px, py, 1'b0});
			case (orient)
			CASE_XMAJOR: begin
				if (acc_one > acc_two) begin
					acc_two = acc_two + adx - acc_one;
					acc_one = '0;
					py = y_back ? py - 1'b1 : py + 1'b1;
				end
				acc_one = acc_one + ady;
				px = x_back ? px - 1'b1 : px + 1'b1;
			end
			CASE_YMAJOR: begin
				if (acc_one > acc_two) begin
					acc_two = acc_two + ady - acc_one;
					acc_one = '0;
					px = x_back ? px - 1'b1 : px + 1'b1;
				end
				acc_one = acc_one + adx;
				py = y_back ? py - 1'b1 : py + 1'b1;
			end
			default: begin
				px = x_back ? px - 1'b1 : px + 1'b1;
				py = y_back ? py - 1'b1 : py + 1'b1;
			end
			endcase
		end
		expected_pixels.push_back('{req.ex, req.ey, 1'b1});
	endfunction

	function automatic void queue_line(input int sx, input int sy, input int ex, input int ey);
		line_req_t req;
		req = '{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)};
		pending_lines.push_back(req);
	endfunction

	// a coordinate within three of c, clamped to the grid
	function automatic coord_t nudge(input coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return coord_t'(v);
	endfunction

	// random line: free endpoints in four of ten, plus points, axis lines, diagonals, short lines
	function automatic void queue_random_line();
		line_req_t req;
		int        span;
		req.sx = coord_t'($urandom_range(COORD_MAX));
		req.sy = coord_t'($urandom_range(COORD_MAX));
		req.ex = coord_t'($urandom_range(COORD_MAX));
		req.ey = coord_t'($urandom_range(COORD_MAX));
		case ($urandom_range(9))
		0: begin
			req.ex = req.sx;
			req.ey = req.sy;
		end
		1: req.ey = req.sy;
		2: req.ex = req.sx;
		3: begin
			span = int'($urandom_range(COORD_MAX));
			req.sx = coord_t'($urandom_range(COORD_MAX - span));
			req.sy = coord_t'($urandom_range(COORD_MAX - span));
			req.ex = req.sx + coord_t'(span);
			req.ey = req.sy + coord_t'(span);
			if ($urandom_range(1)) {req.sx, req.ex} = {req.ex, req.sx};
			if ($urandom_range(1)) {req.sy, req.ey} = {req.ey, req.sy};
		end
		4, 5: begin
			req.ex = nudge(req.sx);
			req.ey = nudge(req.sy);
		end
		default: ;
		endcase
		pending_lines.push_back(req);
	endfunction

	// request driver: holds each beat until taken, gaps at random between beats
	always @(posedge clk or negedge arst_n) begin : drive_lines
		line_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			lines_taken <= 0;
		end else begin
			if (in_valid && in_ready) lines_taken <= lines_taken + 1;
			if (!in_valid || in_ready) begin
				if (pending_lines.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
					nxt = pending_lines.pop_front();
					in_valid <= 1'b1;
					start_x <= nxt.sx;
					start_y <= nxt.sy;
					end_x <= nxt.ex;
					end_y <= nxt.ey;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor: random back-pressure, checks each beat, then predicts new lines
	always @(posedge clk or negedge arst_n) begin : check_pixels
		pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 35);
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected beat: point_x %0d point_y %0d last_point %0b",
						point_x, point_y, last_point);
					failures = failures + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (point_x !== want.px) begin
						$error("point_x: expected %0d, got %0d", want.px, point_x);
						failures = failures + 1;
					end
					if (point_y !== want.py) begin
						$error("point_y: expected %0d, got %0d", want.py, point_y);
						failures = failures + 1;
					end
					if (last_point !== want.last) begin
						$error("last_point: expected %0b, got %0b", want.last, last_point);
						failures = failures + 1;
					end
				end
			end
			if (in_valid && in_ready) plot_line('{start_x, start_y, end_x, end_y});
		end
	end

	initial begin
		// zero-length lines at the grid corners
		queue_line(0, 0, 0, 0);
		queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		// full-length diagonals in all four directions
		queue_line(0, 0, COORD_MAX, COORD_MAX);
		queue_line(COORD_MAX, COORD_MAX, 0, 0);
		queue_line(COORD_MAX, 0, 0, COORD_MAX);
		queue_line(0, COORD_MAX, COORD_MAX, 0);
		// horizontal and vertical, both directions
		queue_line(0, 0, COORD_MAX, 0);
		queue_line(COORD_MAX, 5, 0, 5);
		queue_line(7, 0, 7, COORD_MAX);
		queue_line(7, COORD_MAX, 7, 0);
		// nearly axis-aligned x-major and y-major lines
		queue_line(0, 0, COORD_MAX, 1);
		queue_line(COORD_MAX, COORD_MAX, 0, COORD_MAX - 1);
		queue_line(0, COORD_MAX, COORD_MAX, COORD_MAX - 1);
		queue_line(0, 0, 1, COORD_MAX);
		queue_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, 0);
		// half slopes and a steep line running down and right
		queue_line(0, 0, COORD_MAX, 31);
		queue_line(COORD_MAX, 0, 0, 32);
		queue_line(10, 60, 42, 2);
		// short lines of one and two steps
		queue_line(1, 2, 3, 3);
		queue_line(42, 21, 42, 22);
		repeat (160) queue_random_line();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_lines.size() != 0 || in_valid) @(negedge clk);
		while (expected_pixels.size() != 0) @(negedge clk);
		// catch stray beats after the last end point
		repeat (12) @(negedge clk);
		if (failures == 0) begin
			$display("[bresenham_line_stepper_unit] OK");
		end else begin
			$display("[bresenham_line_stepper_unit] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("[bresenham_line_stepper_unit] ERROR");
		$finish;
	end

endmodule
